// ===== src/kway_merge_descending_unit_defines.svh =====
// Assertion macros shared by the checkers of the merge unit.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef KWAY_MERGE_DESCENDING_UNIT_DEFINES_SVH
`define KWAY_MERGE_DESCENDING_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KWM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define KWM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/kwm_pkg.sv =====
package kwm_pkg;

  localparam int unsigned MAX_LISTS  = 6;
  localparam int unsigned LIST_DEPTH = 256;

  localparam int unsigned OP_W   = 2;
  localparam int unsigned IDX_W  = 3;
  localparam int unsigned VAL_W  = 31;
  localparam int unsigned ST_W   = 2;
  localparam int unsigned CFG_W  = 3;

  localparam int unsigned POS_W     = $clog2(LIST_DEPTH);
  localparam int unsigned CNT_W     = $clog2(LIST_DEPTH + 1);
  localparam int unsigned ADDR_W    = IDX_W + POS_W;
  localparam int unsigned MEM_DEPTH = MAX_LISTS * LIST_DEPTH;

  localparam logic [CFG_W-1:0] LISTS_RESET = CFG_W'(MAX_LISTS);

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_POP    = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_REJECTED  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_DRAIN,
    S_COMMIT,
    S_FINISH
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic do_clear;
    logic do_append;
    logic set_result;
    logic scan_start;
    logic scan_step;
    logic commit;
    logic emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_e  op;
    logic scan_last;
    logic out_free;
  } stat_t;

endpackage

// ===== src/kwm_in_if.sv =====
interface kwm_in_if;
  logic                          valid;
  logic                          ready;
  logic [kwm_pkg::OP_W-1:0]      operation;
  logic [kwm_pkg::IDX_W-1:0]     list_index;
  logic [kwm_pkg::VAL_W-1:0]     value;

  modport source (output valid, output operation, output list_index, output value,
                  input ready);
  modport sink   (input valid, input operation, input list_index, input value,
                  output ready);
endinterface

// ===== src/kwm_out_if.sv =====
interface kwm_out_if;
  logic                          valid;
  logic                          ready;
  logic [kwm_pkg::VAL_W-1:0]     merged_value;
  logic [kwm_pkg::ST_W-1:0]      status;

  modport source (output valid, output merged_value, output status, input ready);
  modport sink   (input valid, input merged_value, input status, output ready);
endinterface

// ===== src/kwm_ctrl.sv =====
module kwm_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  kwm_pkg::stat_t stat_i,
  output kwm_pkg::cmd_t  cmd_o
);

  kwm_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kwm_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      kwm_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = kwm_pkg::S_DECODE;
        end
      end
      kwm_pkg::S_DECODE: begin
        case (stat_i.op)
          kwm_pkg::OP_CLEAR: begin
            cmd_o.do_clear   = 1'b1;
            cmd_o.set_result = 1'b1;
            state_d          = kwm_pkg::S_FINISH;
          end
          kwm_pkg::OP_APPEND: begin
            cmd_o.do_append  = 1'b1;
            cmd_o.set_result = 1'b1;
            state_d          = kwm_pkg::S_FINISH;
          end
          kwm_pkg::OP_POP: begin
            cmd_o.scan_start = 1'b1;
            state_d          = kwm_pkg::S_SCAN;
          end
          default: begin
            cmd_o.set_result = 1'b1;
            state_d          = kwm_pkg::S_FINISH;
          end
        endcase
      end
      kwm_pkg::S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (stat_i.scan_last) begin
          state_d = kwm_pkg::S_DRAIN;
        end
      end
      kwm_pkg::S_DRAIN: begin
        state_d = kwm_pkg::S_COMMIT;
      end
      kwm_pkg::S_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = kwm_pkg::S_FINISH;
      end
      kwm_pkg::S_FINISH: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = kwm_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = kwm_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== src/kwm_datapath.sv =====
module kwm_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [kwm_pkg::CFG_W-1:0]   cfg_wdata_i,
  input  logic [kwm_pkg::OP_W-1:0]    operation_i,
  input  logic [kwm_pkg::IDX_W-1:0]   list_index_i,
  input  logic [kwm_pkg::VAL_W-1:0]   value_i,
  input  kwm_pkg::cmd_t               cmd_i,
  output kwm_pkg::stat_t              stat_o,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic [kwm_pkg::VAL_W-1:0]   merged_value_o,
  output logic [kwm_pkg::ST_W-1:0]    status_o
);

  // Item registers.
  kwm_pkg::op_e                 op_q;
  logic [kwm_pkg::IDX_W-1:0]    idx_q;
  logic [kwm_pkg::VAL_W-1:0]    val_q;

  logic [kwm_pkg::CFG_W-1:0]    lists_q;
  logic [kwm_pkg::CFG_W-1:0]    n_act;
  logic [kwm_pkg::CFG_W-1:0]    n_last;

  logic [kwm_pkg::CNT_W-1:0]    fill_q [kwm_pkg::MAX_LISTS];
  logic [kwm_pkg::CNT_W-1:0]    pos_q  [kwm_pkg::MAX_LISTS];

  logic [kwm_pkg::VAL_W-1:0]    mem [kwm_pkg::MEM_DEPTH];
  logic [kwm_pkg::VAL_W-1:0]    rdata_q;
  logic [kwm_pkg::ADDR_W-1:0]   wr_addr;
  logic [kwm_pkg::ADDR_W-1:0]   rd_addr;
  logic                         wr_en;

  // Scan state.
  logic [kwm_pkg::IDX_W-1:0]    cnt_q;
  logic                         pend_q;
  logic [kwm_pkg::IDX_W-1:0]    pend_idx_q;
  logic                         found_q;
  logic [kwm_pkg::VAL_W-1:0]    best_q;
  logic [kwm_pkg::IDX_W-1:0]    win_q;

  logic [kwm_pkg::VAL_W-1:0]    res_val_q;
  kwm_pkg::status_e             res_st_q;

  logic                         out_valid_q;
  logic [kwm_pkg::VAL_W-1:0]    out_val_q;
  logic [kwm_pkg::ST_W-1:0]     out_st_q;

  logic [kwm_pkg::CNT_W-1:0]    fill_sel;
  logic [kwm_pkg::CNT_W-1:0]    s_pos;
  logic [kwm_pkg::CNT_W-1:0]    s_fill;
  logic                         s_has;
  logic                         reject;
  logic                         take;

  // A count of zero acts as one, and counts above the number of lists saturate.
  always_comb begin
    if (lists_q == '0) begin
      n_act = kwm_pkg::CFG_W'(1);
    end else if (lists_q > kwm_pkg::CFG_W'(kwm_pkg::MAX_LISTS)) begin
      n_act = kwm_pkg::CFG_W'(kwm_pkg::MAX_LISTS);
    end else begin
      n_act = lists_q;
    end
    n_last = n_act - kwm_pkg::CFG_W'(1);
  end

  assign fill_sel = fill_q[idx_q];
  assign reject   = (idx_q >= n_act) || (val_q == '0) ||
                    (fill_sel >= kwm_pkg::CNT_W'(kwm_pkg::LIST_DEPTH));
  assign wr_en    = cmd_i.do_append && !reject;
  assign wr_addr  = {idx_q, fill_sel[kwm_pkg::POS_W-1:0]};

  assign s_pos    = pos_q[cnt_q];
  assign s_fill   = fill_q[cnt_q];
  assign s_has    = s_pos < s_fill;
  assign rd_addr  = {cnt_q, s_pos[kwm_pkg::POS_W-1:0]};

  // Equal heads keep the earlier, lower-indexed winner.
  assign take = pend_q && (!found_q || (rdata_q > best_q));

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= val_q;
    end
    rdata_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      op_q  <= kwm_pkg::op_e'(operation_i);
      idx_q <= list_index_i;
      val_q <= value_i;
    end
    if (cmd_i.scan_step) begin
      pend_idx_q <= cnt_q;
    end
    if (take) begin
      best_q <= rdata_q;
      win_q  <= pend_idx_q;
    end
    if (cmd_i.set_result) begin
      res_val_q <= '0;
      res_st_q  <= (op_q == kwm_pkg::OP_APPEND && reject) ? kwm_pkg::ST_REJECTED
                                                           : kwm_pkg::ST_OK;
    end else if (cmd_i.commit) begin
      res_val_q <= found_q ? best_q : '0;
      res_st_q  <= found_q ? kwm_pkg::ST_OK : kwm_pkg::ST_EXHAUSTED;
    end
    if (cmd_i.emit) begin
      out_val_q <= res_val_q;
      out_st_q  <= res_st_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lists_q     <= kwm_pkg::LISTS_RESET;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < kwm_pkg::MAX_LISTS; i++) begin
        fill_q[i] <= '0;
        pos_q[i]  <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        lists_q <= cfg_wdata_i;
      end
      if (cmd_i.scan_start) begin
        cnt_q   <= '0;
        pend_q  <= 1'b0;
        found_q <= 1'b0;
      end else begin
        pend_q <= cmd_i.scan_step && s_has;
        if (cmd_i.scan_step) begin
          cnt_q <= cnt_q + kwm_pkg::IDX_W'(1);
        end
        if (take) begin
          found_q <= 1'b1;
        end
      end
      if (cmd_i.do_clear) begin
        for (int i = 0; i < kwm_pkg::MAX_LISTS; i++) begin
          fill_q[i] <= '0;
          pos_q[i]  <= '0;
        end
      end
      if (wr_en) begin
        fill_q[idx_q] <= fill_sel + kwm_pkg::CNT_W'(1);
      end
      if (cmd_i.commit && found_q) begin
        pos_q[win_q] <= pos_q[win_q] + kwm_pkg::CNT_W'(1);
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign stat_o.op        = op_q;
  assign stat_o.scan_last = (cnt_q == n_last);
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign merged_value_o = out_val_q;
  assign status_o       = out_st_q;

endmodule

// ===== src/kway_merge_descending_unit.sv =====
// Channel   Direction  Handshake     Payload
// in_i      sink       valid/ready   operation, list_index, value
// out_o     source     valid/ready   merged_value, status
// cfg       write      cfg_we_i      cfg_wdata_i (lists in use)
//
// A clear, an append or an unknown operation passes from acceptance through decode
// and result, where it waits for a free output register, back to idle. A pop passes
// through decode, a scan of the heads of the lists in use, drain, commit and result;
// the list store has one read port, so the heads are fetched one per cycle.
// Reset clears the fill counts, read positions and handshake state; the store is not cleared.
// A result that is not taken holds the output register, while the next item is still accepted.
module kway_merge_descending_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [kwm_pkg::CFG_W-1:0] cfg_wdata_i,
  kwm_in_if.sink                    in_i,
  kwm_out_if.source                 out_o
);

  // Commands and status are the only link between controller and datapath.
  kwm_pkg::cmd_t  cmd;
  kwm_pkg::stat_t stat;
  logic           in_ready;

  kwm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // The datapath holds the list store, the per-list counters, the running
  // maximum of the head scan and the output register.
  kwm_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .operation_i    (in_i.operation),
    .list_index_i   (in_i.list_index),
    .value_i        (in_i.value),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .out_ready_i    (out_o.ready),
    .out_valid_o    (out_o.valid),
    .merged_value_o (out_o.merged_value),
    .status_o       (out_o.status)
  );

  assign in_i.ready = in_ready;

endmodule

// ===== src/kwm_checker.sv =====
`include "kway_merge_descending_unit_defines.svh"

module kwm_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_i,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic [kwm_pkg::VAL_W-1:0] merged_value_i,
  input logic [kwm_pkg::ST_W-1:0]  status_i
);

  // A result waiting for the sink keeps its value and status.
  `KWM_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i,
    out_valid_i && $stable(merged_value_i) && $stable(status_i), "stalled result changed")

  // Only one item is in work at a time.
  `KWM_ASSERT_NEXT(a_one_item, in_valid_i && in_ready_i, !in_ready_i,
    "item accepted while another is in work")

  // Any result other than ok carries a zero value.
  `KWM_ASSERT_SAME(a_zero_val, out_valid_i && status_i != kwm_pkg::ST_OK,
    merged_value_i == '0, "nonzero value with a failure status")

endmodule

bind kway_merge_descending_unit kwm_checker u_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .merged_value_i (out_o.merged_value),
  .status_i       (out_o.status)
);

// ===== tb/kway_merge_descending_unit_check.sv =====
module kway_merge_descending_unit_check import kwm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CFG_W-1:0]  cfg_wdata_i,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [OP_W-1:0]   in_operation_i,
  input  logic [IDX_W-1:0]  in_list_index_i,
  input  logic [VAL_W-1:0]  in_value_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic [VAL_W-1:0]  out_merged_value_i,
  input  logic [ST_W-1:0]   out_status_i,
  output int unsigned       fail_count_o,
  output int unsigned       pending_o,
  output int unsigned       results_o,
  output int unsigned       pops_o,
  output int unsigned       exhausted_o,
  output int unsigned       rejected_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [VAL_W-1:0] merged_value;
    status_e          status;
  } merge_result_t;

  merge_result_t    merge_results_q[$];
  logic [VAL_W-1:0] list_mem [MAX_LISTS][LIST_DEPTH];
  logic [CNT_W-1:0] fill_cnt [MAX_LISTS];
  logic [CNT_W-1:0] rd_pos [MAX_LISTS];
  logic [CFG_W-1:0] lists_reg;
  int unsigned      fail_total, results_total, pops_total, exhausted_total, rejected_total;

  function automatic int unsigned lists_active();
    if (lists_reg == '0) return 1;
    if (lists_reg > MAX_LISTS) return MAX_LISTS;
    return lists_reg;
  endfunction

  // Applies one item to the local copy of the lists and returns its result.
  function automatic merge_result_t merge_step(op_e op, logic [IDX_W-1:0] idx,
                                               logic [VAL_W-1:0] val);
    merge_result_t    res;
    int unsigned      n;
    int unsigned      win;
    bit               found;
    logic [VAL_W-1:0] best;
    logic [VAL_W-1:0] head;
    res.merged_value = '0;
    res.status       = ST_OK;
    n     = lists_active();
    win   = 0;
    found = 1'b0;
    best  = '0;
    case (op)
      OP_CLEAR: begin
        for (int i = 0; i < MAX_LISTS; i++) begin
          fill_cnt[i] = '0;
          rd_pos[i]   = '0;
        end
      end
      OP_APPEND: begin
        if (idx >= n || val == '0 || fill_cnt[idx] >= LIST_DEPTH) begin
          res.status = ST_REJECTED;
        end else begin
          list_mem[idx][fill_cnt[idx]] = val;
          fill_cnt[idx] = fill_cnt[idx] + 1'b1;
        end
      end
      OP_POP: begin
        for (int i = 0; i < n; i++) begin
          if (rd_pos[i] < fill_cnt[i]) begin
            head = list_mem[i][rd_pos[i]];
            // Strictly greater, so the lowest index wins a tie.
            if (!found || head > best) begin
              found = 1'b1;
              best  = head;
              win   = i;
            end
          end
        end
        if (found) begin
          res.merged_value = best;
          rd_pos[win] = rd_pos[win] + 1'b1;
        end else begin
          res.status = ST_EXHAUSTED;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    fail_total++;
  endtask

  task automatic check_result();
    merge_result_t want;
    if (merge_results_q.size() == 0) begin
      report_mismatch($sformatf("result with nothing awaited: value %0h status %0d",
                                out_merged_value_i, out_status_i));
      return;
    end
    want = merge_results_q.pop_front();
    results_total++;
    if (out_merged_value_i !== want.merged_value)
      report_mismatch($sformatf("merged_value %0h, expected %0h",
                                out_merged_value_i, want.merged_value));
    if (out_status_i !== want.status)
      report_mismatch($sformatf("status %0d, expected %0d", out_status_i, want.status));
    case (want.status)
      ST_OK:        if (want.merged_value != '0) pops_total++;
      ST_EXHAUSTED: exhausted_total++;
      ST_REJECTED:  rejected_total++;
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      merge_results_q.delete();
      for (int i = 0; i < MAX_LISTS; i++) begin
        fill_cnt[i] = '0;
        rd_pos[i]   = '0;
      end
      lists_reg = LISTS_RESET;
    end else begin
      if (cfg_we_i) lists_reg = cfg_wdata_i;
      // A result leaving always belongs to an older item than one arriving.
      if (out_valid_i && out_ready_i) check_result();
      if (in_valid_i && in_ready_i)
        merge_results_q.push_back(merge_step(op_e'(in_operation_i), in_list_index_i,
                                             in_value_i));
    end
    pending_o    <= merge_results_q.size();
    fail_count_o <= fail_total;
    results_o    <= results_total;
    pops_o       <= pops_total;
    exhausted_o  <= exhausted_total;
    rejected_o   <= rejected_total;
  end

endmodule

// ===== tb/kway_merge_descending_unit_test.sv =====
module kway_merge_descending_unit_test import kwm_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  // Generous bound: the slowest run stays well under it.
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned PHASE_ITEMS = 10;
  localparam int unsigned TAIL_CYCLES = 32;
  // Settings of the lists-in-use register visited by the random phases, in order.
  // Zero is exercised by the directed part; seven must behave as six.
  localparam int unsigned PHASE_LISTS [8] = '{6, 3, 1, 2, 7, 5, 4, 6};

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CFG_W-1:0] cfg_wdata_i;

  kwm_in_if  in_if ();
  kwm_out_if out_if ();

  int unsigned fail_count, pending, results, pops, exhausted, rejected;
  int unsigned cycle_count;

  // Stimulus-side view: how many lists take part, and the last value appended
  // to each list so that most appends keep the lists in descending order.
  int unsigned      lists_now;
  logic [VAL_W-1:0] tail [8];
  bit               steady_mode;
  bit               hold_req;

  kway_merge_descending_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  kway_merge_descending_unit_check u_check (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_if.valid),
    .in_ready_i         (in_if.ready),
    .in_operation_i     (in_if.operation),
    .in_list_index_i    (in_if.list_index),
    .in_value_i         (in_if.value),
    .out_valid_i        (out_if.valid),
    .out_ready_i        (out_if.ready),
    .out_merged_value_i (out_if.merged_value),
    .out_status_i       (out_if.status),
    .fail_count_o       (fail_count),
    .pending_o          (pending),
    .results_o          (results),
    .pops_o             (pops),
    .exhausted_o        (exhausted),
    .rejected_o         (rejected)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Watchdog. If the run is still going at the limit, something has hung.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("kway_merge_descending_unit_test: errors");
    $finish;
  end

  // Idle lengths shared by both sides: mostly none or short, now and then long.
  // In steady mode every idle length is zero.
  function automatic int unsigned gap_len();
    int unsigned r;
    if (steady_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // The receiver. Each pass through the loop makes at most one assignment to
  // ready per clock edge. A hold request makes it refuse results for a long
  // stretch, so the block fills up and has to stop taking items.
  initial begin : result_taker
    int unsigned stall;
    forever begin
      if (hold_req) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        stall = gap_len();
        if (stall != 0) begin
          out_if.ready <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
        out_if.ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // Offers one item, after an optional idle gap, and returns at the edge where
  // it is taken. Valid is left high, so back-to-back items never lower and
  // raise it within one time step.
  task automatic push_item(input op_e op, input logic [IDX_W-1:0] idx,
                           input logic [VAL_W-1:0] val);
    int unsigned gap;
    gap = gap_len();
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.operation  <= op;
    in_if.list_index <= idx;
    in_if.value      <= val;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
  endtask

  // Stops offering and waits until every awaited result has been taken. The
  // first edge lets the count take in an item accepted at the current edge.
  task automatic settle();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Only called once the block is idle.
  task automatic write_lists(input int unsigned setting);
    cfg_wdata_i <= CFG_W'(setting);
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    if (setting == 0) lists_now = 1;
    else if (setting > MAX_LISTS) lists_now = MAX_LISTS;
    else lists_now = setting;
  endtask

  task automatic clear_lists();
    push_item(OP_CLEAR, IDX_W'($urandom), VAL_W'($urandom));
    foreach (tail[i]) tail[i] = '0;
  endtask

  // Next value for a list kept in descending order. A fresh list starts at a
  // random point of the whole range; repeats are common so that duplicates and
  // ties between lists show up.
  function automatic logic [VAL_W-1:0] next_sorted(int unsigned idx);
    logic [VAL_W-1:0] cur;
    cur = tail[idx];
    if (cur == '0) begin
      cur = VAL_W'($urandom) | VAL_W'(1);
    end else begin
      case ($urandom_range(0, 3))
        0: ;
        1: cur = cur - VAL_W'($urandom_range(0, 3));
        default: cur = cur - VAL_W'($urandom_range(0, cur >> 3));
      endcase
    end
    if (cur == '0) cur = VAL_W'(1);
    tail[idx] = cur;
    return cur;
  endfunction

  // Random traffic: mostly well-formed appends to lists in use and pops, with
  // a sprinkling of refused appends, out-of-order values, clears and no-ops.
  task automatic run_mixed(input int unsigned count);
    int unsigned      r;
    int unsigned      idx;
    logic [VAL_W-1:0] val;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (r < 48) begin
        idx = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7)
                                          : $urandom_range(0, lists_now - 1);
        case ($urandom_range(0, 19))
          0:       val = '0;
          1:       val = VAL_W'($urandom);
          default: val = next_sorted(idx);
        endcase
        push_item(OP_APPEND, IDX_W'(idx), val);
      end else if (r < 92) begin
        push_item(OP_POP, IDX_W'($urandom), VAL_W'($urandom));
      end else if (r < 96) begin
        clear_lists();
      end else begin
        push_item(OP_NOP, IDX_W'($urandom), VAL_W'($urandom));
      end
    end
  endtask

  initial begin : stimulus
    rst_ni           = 1'b0;
    cfg_we_i         <= 1'b0;
    cfg_wdata_i      <= '0;
    in_if.valid      <= 1'b0;
    in_if.operation  <= OP_NOP;
    in_if.list_index <= '0;
    in_if.value      <= '0;
    steady_mode      = 1'b0;
    hold_req         = 1'b0;
    lists_now        = MAX_LISTS;
    foreach (tail[i]) tail[i] = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part, with all six lists in use after reset.
    // A pop with nothing stored reports exhaustion.
    push_item(OP_POP, '0, '0);
    // Two lists share the largest value, so list 0 must win the tie.
    push_item(OP_APPEND, 3'd0, 31'h7FFF_FFFF);
    push_item(OP_APPEND, 3'd2, 31'h7FFF_FFFF);
    // List 5 is given a rising pair, which the block does not check.
    push_item(OP_APPEND, 3'd5, 31'd1);
    push_item(OP_APPEND, 3'd5, 31'd1000);
    // A zero value and lists outside the six in use are refused.
    push_item(OP_APPEND, 3'd0, '0);
    push_item(OP_APPEND, 3'd6, 31'd7);
    push_item(OP_APPEND, 3'd7, 31'h2AAA_AAAA);
    push_item(OP_APPEND, 3'd3, 31'h5555_5555);
    push_item(OP_APPEND, 3'd4, 31'h2AAA_AAAA);
    push_item(OP_NOP, 3'd7, 31'h7FFF_FFFF);
    // Drain everything, one pop more than there are values.
    repeat (7) push_item(OP_POP, 3'd7, 31'h7FFF_FFFF);
    // A clear throws away what is stored.
    push_item(OP_APPEND, 3'd1, 31'd5);
    push_item(OP_CLEAR, 3'd5, 31'd3);
    push_item(OP_POP, '0, '0);
    // A setting of zero behaves as a single list.
    settle();
    write_lists(0);
    push_item(OP_APPEND, 3'd1, 31'd9);
    push_item(OP_APPEND, 3'd0, 31'd9);
    push_item(OP_POP, '0, '0);
    push_item(OP_POP, '0, '0);

    // Random phases. Only some start with a clear, so lists that drop out
    // when the setting shrinks come back with their contents when it grows.
    foreach (PHASE_LISTS[p]) begin
      settle();
      write_lists(PHASE_LISTS[p]);
      steady_mode = (p % 3 == 1);
      if ($urandom_range(0, 2) == 0) clear_lists();
      if (PHASE_LISTS[p] == 1) begin
        // Fill the only list past its depth, then pop it dry and two beyond.
        clear_lists();
        repeat (LIST_DEPTH + 3) push_item(OP_APPEND, '0, next_sorted(0));
        repeat (LIST_DEPTH + 2) push_item(OP_POP, IDX_W'($urandom), VAL_W'($urandom));
      end
      // In the first steady phase the receiver stops for a long time while
      // items keep coming, until the block has to refuse them.
      if (p == 1) hold_req = 1'b1;
      run_mixed(PHASE_ITEMS);
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("covered %0d results: %0d pops with data, %0d exhausted pops, %0d refused appends",
             results, pops, exhausted, rejected);
    $display("lists in use swept from zero to seven, one list filled to its full depth");
    if (fail_count == 0) begin
      $display("kway_merge_descending_unit_test: clean");
    end else begin
      $display("kway_merge_descending_unit_test: errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/kwm_pkg.sv
src/kwm_in_if.sv
src/kwm_out_if.sv
src/kwm_ctrl.sv
src/kwm_datapath.sv
src/kway_merge_descending_unit.sv
src/kwm_checker.sv
tb/kway_merge_descending_unit_check.sv
tb/kway_merge_descending_unit_test.sv
